/* design/sdw_pkg.sv */
// ----------------------------------------------------------------------------
// sdw_pkg: shared types and constants of the slot departure watchdog
// Per-slot record layout, register indexes, action and status codes.
// ----------------------------------------------------------------------------
package sdw_pkg;

  // Field widths
  localparam int unsigned POS_W   = 24;
  localparam int unsigned THR_W   = 23;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SLOT_IN_W = 8;
  localparam int unsigned STAT_W  = 2;
  // magnitude of a position difference and its square
  localparam int unsigned MAG_W   = POS_W + 1;
  localparam int unsigned SQ_W    = 2 * MAG_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHECKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 1'd1;

  localparam logic [CFG_W-1:0] MIN_CHECKS_RST  = 8'd3;
  localparam logic [CFG_W-1:0] MAX_RETRIES_RST = 8'd2;

  // Request actions
  localparam logic ACT_CHECK = 1'b0;
  localparam logic ACT_RESET = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_NONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEPARTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RETRY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ESCALATE = 2'd3;

  // Per-slot record kept in the slot RAM
  typedef struct packed {
    logic                    active;
    logic                    departed;
    logic [CNT_W-1:0]        ticks;
    logic [CNT_W-1:0]        retries;
    logic signed [POS_W-1:0] base_x;
    logic signed [POS_W-1:0] base_y;
  } slot_rec_t;

  // Control of the shared squaring unit
  typedef struct packed {
    logic op_ld;    // load a new operand
    logic acc_ld;   // acc <= product
    logic acc_add;  // acc <= acc + product
  } sq_ctrl_t;

endpackage

/* design/sdw_in_if.sv */
// ----------------------------------------------------------------------------
// sdw_in_if: request channel of the slot departure watchdog
// Valid/ready handshake carrying one check or reset request.
// ----------------------------------------------------------------------------
interface sdw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic [sdw_pkg::SLOT_IN_W-1:0]          slot;
  logic                                   object_present;
  logic signed [sdw_pkg::POS_W-1:0]       pos_x;
  logic signed [sdw_pkg::POS_W-1:0]       pos_y;
  logic [sdw_pkg::THR_W-1:0]              threshold;

  modport source (output valid, action, slot, object_present, pos_x, pos_y, threshold,
                  input ready);
  modport sink   (input valid, action, slot, object_present, pos_x, pos_y, threshold,
                  output ready);
endinterface

/* design/sdw_out_if.sv */
// ----------------------------------------------------------------------------
// sdw_out_if: result channel of the slot departure watchdog
// Valid/ready handshake carrying status and the slot's retry count.
// ----------------------------------------------------------------------------
interface sdw_out_if;
  logic                          valid;
  logic                          ready;
  logic [sdw_pkg::STAT_W-1:0]    status;
  logic [sdw_pkg::CNT_W-1:0]     retry_count;

  modport source (output valid, status, retry_count, input ready);
  modport sink   (input valid, status, retry_count, output ready);
endinterface

/* design/sdw_ram.sv */
// ----------------------------------------------------------------------------
// sdw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sdw_sq_unit.sv */
// ----------------------------------------------------------------------------
// sdw_sq_unit: shared squaring unit with accumulator
// Squares one operand per cycle into a product register and sums products.
// ----------------------------------------------------------------------------
module sdw_sq_unit (
  input  logic                       clk_i,
  input  sdw_pkg::sq_ctrl_t          ctrl_i,
  input  logic [sdw_pkg::MAG_W-1:0]  op_i,
  output logic [sdw_pkg::SQ_W-1:0]   prod_o,
  output logic [sdw_pkg::SQ_W-1:0]   acc_o
);

  logic [sdw_pkg::MAG_W-1:0] op_q;
  logic [sdw_pkg::SQ_W-1:0]  prod_q;
  logic [sdw_pkg::SQ_W-1:0]  acc_q;

  // operand -> square, one multiply per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op_ld) begin
      op_q <= op_i;
    end
    prod_q <= sdw_pkg::SQ_W'(op_q) * sdw_pkg::SQ_W'(op_q);
  end

  // accumulate squares; sum of two squares stays below 2^49
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_ld) begin
      acc_q <= prod_q;
    end else if (ctrl_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

/* design/slot_departure_watchdog.sv */
// ----------------------------------------------------------------------------
// slot_departure_watchdog: per-slot departure check with retries
// Tracks a baseline per slot and flags when squared distance reaches the
// squared threshold, with retry and escalation handling.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------
//  req_i     | in  | valid / ready    | action, slot, object_present, pos, thr
//  rsp_o     | out | valid / ready    | status, retry_count
//  cfg       | in  | cfg_we_i         | cfg_idx_i, cfg_data_i
//
//  An in-range request goes from accept to result valid through one RAM read,
//  three passes through the shared squarer (dx^2, dy^2, thr^2) and a
//  compare/update state. Out-of-range slots return in the cycle after accept.
//  One request at a time: req_i.ready is low until the result is taken.
//  Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_departure_watchdog #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sdw_in_if.sink                        req_i,
  sdw_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [sdw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdw_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned REC_W  = $bits(sdw_pkg::slot_rec_t);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_LD   = 3'd2;
  localparam logic [2:0] ST_SX   = 3'd3;
  localparam logic [2:0] ST_SY   = 3'd4;
  localparam logic [2:0] ST_ST   = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  // Latched request
  logic                                 action_q;
  logic [SLOT_W-1:0]                    slot_q;
  logic                                 present_q;
  logic signed [sdw_pkg::POS_W-1:0]     pos_x_q;
  logic signed [sdw_pkg::POS_W-1:0]     pos_y_q;
  logic [sdw_pkg::THR_W-1:0]            thr_q;

  // Configuration
  logic [sdw_pkg::CFG_W-1:0] min_checks_q;
  logic [sdw_pkg::CFG_W-1:0] max_retries_q;

  // Slot storage
  logic [NUM_SLOTS-1:0]  vld_q;
  logic [REC_W-1:0]      ram_rdata;
  sdw_pkg::slot_rec_t    ram_rec;
  sdw_pkg::slot_rec_t    rec_q;
  sdw_pkg::slot_rec_t    rec_new;

  // Result register
  logic [sdw_pkg::STAT_W-1:0] status_q, status_d;
  logic [sdw_pkg::CNT_W-1:0]  rc_q, rc_d;

  // Squaring unit
  sdw_pkg::sq_ctrl_t         sq_ctrl;
  logic [sdw_pkg::MAG_W-1:0] sq_op;
  logic [sdw_pkg::SQ_W-1:0]  sq_prod;
  logic [sdw_pkg::SQ_W-1:0]  sq_acc;

  logic in_range;
  logic req_fire;
  logic rsp_fire;

  logic signed [sdw_pkg::MAG_W-1:0] diff;
  logic [sdw_pkg::CNT_W-1:0]        ticks_inc;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_o.valid = (state_q == ST_OUT);
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign rsp_o.status      = status_q;
  assign rsp_o.retry_count = rc_q;

  assign in_range = ({1'b0, req_i.slot} < 9'(NUM_SLOTS));

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_checks_q  <= sdw_pkg::MIN_CHECKS_RST;
      max_retries_q <= sdw_pkg::MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdw_pkg::REG_MIN_CHECKS:  min_checks_q  <= cfg_data_i;
        sdw_pkg::REG_MAX_RETRIES: max_retries_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      action_q  <= req_i.action;
      slot_q    <= req_i.slot[SLOT_W-1:0];
      present_q <= req_i.object_present;
      pos_x_q   <= req_i.pos_x;
      pos_y_q   <= req_i.pos_y;
      thr_q     <= req_i.threshold;
    end
  end

  // Slot RAM; a slot never written reads as all zero
  sdw_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_CMP),
    .waddr_i (slot_q),
    .wdata_i (rec_new),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign ram_rec = vld_q[slot_q] ? sdw_pkg::slot_rec_t'(ram_rdata) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == ST_CMP) begin
      vld_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LD) begin
      rec_q <= ram_rec;
    end
  end

  // Operand select for the squarer: |dx|, |dy|, threshold
  always_comb begin
    diff = '0;
    sq_op = '0;
    case (state_q)
      ST_LD: begin
        diff  = {pos_x_q[sdw_pkg::POS_W-1], pos_x_q}
              - {ram_rec.base_x[sdw_pkg::POS_W-1], ram_rec.base_x};
        sq_op = diff[sdw_pkg::MAG_W-1] ? sdw_pkg::MAG_W'(-diff) : sdw_pkg::MAG_W'(diff);
      end
      ST_SX: begin
        diff  = {pos_y_q[sdw_pkg::POS_W-1], pos_y_q}
              - {rec_q.base_y[sdw_pkg::POS_W-1], rec_q.base_y};
        sq_op = diff[sdw_pkg::MAG_W-1] ? sdw_pkg::MAG_W'(-diff) : sdw_pkg::MAG_W'(diff);
      end
      ST_SY: begin
        sq_op = sdw_pkg::MAG_W'(thr_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    sq_ctrl.op_ld   = (state_q == ST_LD) || (state_q == ST_SX) || (state_q == ST_SY);
    sq_ctrl.acc_ld  = (state_q == ST_SY);
    sq_ctrl.acc_add = (state_q == ST_ST);
  end

  sdw_sq_unit u_sq (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .op_i   (sq_op),
    .prod_o (sq_prod),
    .acc_o  (sq_acc)
  );

  // Slot update and result; acc = dx^2 + dy^2, prod = thr^2 in ST_CMP
  assign ticks_inc = (rec_q.ticks == '1) ? rec_q.ticks : rec_q.ticks + 1'b1;

  always_comb begin
    rec_new  = rec_q;
    status_d = sdw_pkg::STAT_NONE;
    rc_d     = rec_q.retries;
    if (action_q == sdw_pkg::ACT_RESET) begin
      rec_new.active   = present_q;
      rec_new.departed = 1'b0;
      rec_new.ticks    = '0;
      rec_new.retries  = '0;
      rec_new.base_x   = present_q ? pos_x_q : '0;
      rec_new.base_y   = present_q ? pos_y_q : '0;
      rc_d             = '0;
    end else if (present_q && rec_q.active) begin
      if (rec_q.departed) begin
        status_d = sdw_pkg::STAT_DEPARTED;
      end else begin
        rec_new.ticks = ticks_inc;
        if (ticks_inc >= min_checks_q) begin
          if (sq_acc >= sq_prod) begin
            rec_new.departed = 1'b1;
            status_d         = sdw_pkg::STAT_DEPARTED;
          end else if (rec_q.retries < max_retries_q) begin
            rec_new.retries = rec_q.retries + 1'b1;
            rec_new.base_x  = pos_x_q;
            rec_new.base_y  = pos_y_q;
            rec_new.ticks   = '0;
            status_d        = sdw_pkg::STAT_RETRY;
          end else begin
            status_d = sdw_pkg::STAT_ESCALATE;
          end
        end
      end
      rc_d = rec_new.retries;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      status_q <= sdw_pkg::STAT_NONE;
      rc_q     <= '0;
    end else if (state_q == ST_CMP) begin
      status_q <= status_d;
      rc_q     <= rc_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_fire) state_d = in_range ? ST_RD : ST_OUT;
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_SX;
      ST_SX:   state_d = ST_SY;
      ST_SY:   state_d = ST_ST;
      ST_ST:   state_d = ST_CMP;
      ST_CMP:  state_d = ST_OUT;
      ST_OUT:  if (rsp_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
